/* design/stpq_pkg.sv */
// shared types and constants for the sorted time priority queue
package stpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned INFO_W       = 8;
  localparam int unsigned COUNT_OUT_W  = 5;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] entry_time;
    logic [INFO_W-1:0] entry_info;
  } entry_t;

  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] entry_time;
    logic [INFO_W-1:0] entry_info;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [TIME_W-1:0]      out_time;
    logic [INFO_W-1:0]      out_info;
    logic [COUNT_OUT_W-1:0] out_count;
  } out_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

/* design/sorted_time_priority_queue.sv */
// top level: row of sorted cells with fill count and registered result
// a result is registered in the output register in the cycle after its input transfer
// throughput: one item per cycle while the input is not stalled; the whole cell row shifts
// in the same cycle as the broadcast key compare, so each item needs a single update of the row
// input stall follows output stall only while a result is held in the output register
// reset clears the fill count and the output valid; cell contents stay undefined
module sorted_time_priority_queue #(
  parameter int unsigned CAPACITY = stpq_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stpq_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stpq_pkg::out_t out_o
);
  import stpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             in_fire;
  logic             full, empty;
  cell_ctrl_t       ctrl;

  logic   [CAPACITY-1:0] occupied;
  logic   [CAPACITY-1:0] after;
  entry_t [CAPACITY-1:0] cell_entry;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = count_q >= CNT_W'(CAPACITY);
  assign empty      = count_q == '0;

  assign ctrl.ins       = in_fire && (in_i.mode == MODE_ENQ) && !full;
  assign ctrl.rem       = in_fire && (in_i.mode == MODE_DEQ) && !empty;
  assign ctrl.new_entry = '{entry_time: in_i.entry_time, entry_info: in_i.entry_info};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_after;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied[i] = count_q > CNT_W'(i);

    if (i == 0) begin : g_head
      assign left_after = 1'b0;
      assign left_entry = cell_entry[0];
    end else begin : g_body
      assign left_after = after[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    stpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied[i]),
      .left_after_i  (left_after),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .after_o       (after[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_d           = out_q;
    out_d.status    = STATUS_DONE;
    out_d.out_time  = '0;
    out_d.out_info  = '0;
    out_d.out_count = COUNT_OUT_W'(count_d);
    if (in_i.mode == MODE_ENQ) begin
      if (full) begin
        out_d.status = STATUS_FULL;
      end
    end else if (empty) begin
      out_d.status = STATUS_EMPTY;
    end else begin
      out_d.out_time = cell_entry[0].entry_time;
      out_d.out_info = cell_entry[0].entry_info;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("good enqueue did not raise the count");

  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !ctrl.ins && !ctrl.rem |=> $stable(count_q))
    else $error("rejected request changed the count");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q && out_q.out_count == COUNT_OUT_W'(count_q))
    else $error("result missing or count mismatch after transfer");

  a_ins_not_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove in the same cycle");

endmodule

/* design/stpq_cell.sv */
// one slot of the sorted entry row
module stpq_cell (
  input  logic                clk_i,
  input  stpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_after_i,
  input  stpq_pkg::entry_t    left_entry_i,
  input  stpq_pkg::entry_t    right_entry_i,
  output logic                after_o,
  output stpq_pkg::entry_t    entry_o
);
  import stpq_pkg::*;

  entry_t entry_q, entry_d;

  // new key belongs before this slot: slot empty or holds a strictly larger key
  assign after_o = !occupied_i || (entry_q.entry_time > ctrl_i.new_entry.entry_time);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_after_i) begin
        entry_d = left_entry_i;
      end else if (after_o) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
